/* rtl/pmu_pkg.sv */
package pmu_pkg;

    // store geometry
    localparam int NODES     = 64;
    localparam int NODE_W    = $clog2(NODES);
    localparam int ENTRY_W   = 32;
    localparam int KEEP_W    = 16;
    localparam int COST_W    = 7;

    // stream and register port widths
    localparam int S_DATA_W  = 24;
    localparam int S_USER_W  = 3;
    localparam int M_DATA_W  = 32;
    localparam int M_USER_W  = 1;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // entry values
    localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};
    localparam logic [ENTRY_W-1:0] SHARE     = ENTRY_W'(65536 / NODES);

    // register reset values
    localparam logic [KEEP_W-1:0]  KEEP_RESET    = KEEP_W'(45875);
    localparam logic [ENTRY_W-1:0] DEPOSIT_RESET = ENTRY_W'(1258291);

    // item kinds
    localparam logic [1:0] ACT_TOUR = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_INIT = 2'd2;

    // register indexes
    localparam logic REG_KEEP    = 1'b0;
    localparam logic REG_DEPOSIT = 1'b1;

endpackage

/* rtl/pheromone_matrix_update.sv */
// channel  direction  fields
// s_*      in         tdata: node, tour_start, tour_cost, read_row; tuser: action, read_first
// m_*      out        tdata: value; tuser: saturated
// apb      in/out     keep_factor at 0, deposit_scale at 4
//
// A later tour node runs one read-modify-write sweep over a row, one entry per cycle
// through the store, which reads one entry while it writes back another, plus the pipeline drain.
// A first tour node first runs the bit-serial deposit divider, skipped for a zero cost.
// Reset is synchronous and needs no clearing pass: per-row valid bits stand for the
// reset contents of the store.
// A stalled result sits in the output register while the next word is taken.
module pheromone_matrix_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // node [5:0], tour_start [6], tour_cost [13:7], read_row [19:14], zero fill
    input  logic [pmu_pkg::S_DATA_W-1:0]  s_tdata,
    // action [1:0], read_first [2]
    input  logic [pmu_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // value [31:0]
    output logic [pmu_pkg::M_DATA_W-1:0]  m_tdata,
    // saturated [0]
    output logic [pmu_pkg::M_USER_W-1:0]  m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmu_pkg::APB_AW-1:0]    paddr,
    input  logic [pmu_pkg::APB_DW-1:0]    pwdata,
    output logic [pmu_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import pmu_pkg::*;

    localparam int CNT_W = NODE_W + 1;
    localparam int DIV_W = $clog2(ENTRY_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SWEEP,
        S_READ,
        S_RDATA,
        S_FIN
    } t_state;

    t_state               r_state;

    // configuration
    logic [KEEP_W-1:0]    r_keep;
    logic [ENTRY_W-1:0]   r_dscale;

    // tour state
    logic [NODE_W-1:0]    r_prev;
    logic [ENTRY_W-1:0]   r_deposit;

    // captured word
    logic [NODE_W-1:0]    r_node;
    logic [NODE_W-1:0]    r_row;
    logic [COST_W-1:0]    r_cost;
    logic                 r_rfirst;

    // store validity
    logic [NODES-1:0]     r_row_valid;
    logic                 r_fc_valid;

    // sweep control
    logic                 r_line_fc;
    logic [NODE_W-1:0]    r_line_row;
    logic [CNT_W-1:0]     r_issue;
    logic                 r_s1_v;
    logic [NODE_W-1:0]    r_s1_col;
    logic                 r_s2_v;
    logic [NODE_W-1:0]    r_s2_col;
    logic [ENTRY_W-1:0]   r_s2_val;

    // divider
    logic [COST_W-1:0]    r_rem;
    logic [ENTRY_W-1:0]   r_quo;
    logic [DIV_W-1:0]     r_div_cnt;

    // result
    logic [ENTRY_W-1:0]   r_res_value;
    logic                 r_res_sat;
    logic                 r_out_valid;
    logic [ENTRY_W-1:0]   r_out_value;
    logic                 r_out_sat;

    // memories
    logic [ENTRY_W-1:0]   r_mx_mem [2**(2*NODE_W)];
    logic [ENTRY_W-1:0]   r_fc_mem [NODES];
    logic [ENTRY_W-1:0]   r_mx_rdata;
    logic [ENTRY_W-1:0]   r_fc_rdata;

    // unpacked input word
    logic [1:0]           in_action;
    logic [NODE_W-1:0]    in_node;
    logic                 in_start;
    logic [COST_W-1:0]    in_cost;
    logic [NODE_W-1:0]    in_row;
    logic                 in_rfirst;
    logic                 s_acc;
    logic                 m_acc;
    logic                 cfg_wr;

    assign in_node   = s_tdata[NODE_W-1:0];
    assign in_start  = s_tdata[NODE_W];
    assign in_cost   = s_tdata[NODE_W+COST_W:NODE_W+1];
    assign in_row    = s_tdata[2*NODE_W+COST_W:NODE_W+COST_W+1];
    assign in_action = s_tuser[1:0];
    assign in_rfirst = s_tuser[2];

    assign s_tready = (r_state == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = r_out_valid && m_tready;

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_value;
    assign m_tuser  = r_out_sat;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr[2])
            REG_KEEP:    prdata = {{(APB_DW-KEEP_W){1'b0}}, r_keep};
            REG_DEPOSIT: prdata = r_dscale;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep   <= KEEP_RESET;
            r_dscale <= DEPOSIT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_KEEP:    r_keep   <= pwdata[KEEP_W-1:0];
                REG_DEPOSIT: r_dscale <= pwdata[ENTRY_W-1:0];
                default:     r_keep   <= r_keep;
            endcase
        end
    end

    // divider step
    logic [COST_W:0]      n_trial;
    logic                 n_ge;
    logic [COST_W:0]      n_diff;
    assign n_trial = {r_rem, r_quo[ENTRY_W-1]};
    assign n_ge    = (n_trial >= {1'b0, r_cost});
    assign n_diff  = n_trial - {1'b0, r_cost};

    // store read addresses
    logic [NODE_W-1:0]    issue_col;
    logic                 issue_go;
    logic [2*NODE_W-1:0]  mx_raddr;
    logic [NODE_W-1:0]    fc_raddr;
    assign issue_col = r_issue[NODE_W-1:0];
    assign issue_go  = (r_state == S_SWEEP) && (r_issue < CNT_W'(NODES));
    assign mx_raddr  = (r_state == S_READ) ? {r_row, r_node} : {r_line_row, issue_col};
    assign fc_raddr  = (r_state == S_READ) ? r_node : issue_col;

    // entry as read, with reset contents where the store was not yet written
    logic [ENTRY_W-1:0]   s1_entry;
    logic [ENTRY_W+KEEP_W-1:0] n_prod;
    always_comb begin
        if (r_line_fc) begin
            s1_entry = r_fc_valid ? r_fc_rdata : SHARE;
        end else if (r_row_valid[r_line_row]) begin
            s1_entry = r_mx_rdata;
        end else begin
            s1_entry = (r_s1_col == r_line_row) ? '0 : SHARE;
        end
    end
    assign n_prod = s1_entry * r_keep;

    // deposit and saturation at write-back
    logic [ENTRY_W:0]     n_sum;
    logic [ENTRY_W-1:0]   wb_data;
    logic                 wb_sat;
    assign n_sum   = {1'b0, r_s2_val} + ((r_s2_col == r_node) ? {1'b0, r_deposit} : '0);
    assign wb_sat  = n_sum[ENTRY_W];
    assign wb_data = wb_sat ? ENTRY_MAX : n_sum[ENTRY_W-1:0];

    // read item value
    logic [ENTRY_W-1:0]   rd_value;
    always_comb begin
        if ({1'b0, r_node} >= CNT_W'(NODES)) begin
            rd_value = '0;
        end else if (r_rfirst) begin
            rd_value = r_fc_valid ? r_fc_rdata : SHARE;
        end else if ({1'b0, r_row} >= CNT_W'(NODES)) begin
            rd_value = '0;
        end else if (r_row_valid[r_row]) begin
            rd_value = r_mx_rdata;
        end else begin
            rd_value = (r_row == r_node) ? '0 : SHARE;
        end
    end

    // matrix memory
    always_ff @(posedge i_clk) begin
        if (r_s2_v && !r_line_fc) begin
            r_mx_mem[{r_line_row, r_s2_col}] <= wb_data;
        end
        r_mx_rdata <= r_mx_mem[mx_raddr];
    end

    // first-choice memory
    always_ff @(posedge i_clk) begin
        if (r_s2_v && r_line_fc) begin
            r_fc_mem[r_s2_col] <= wb_data;
        end
        r_fc_rdata <= r_fc_mem[fc_raddr];
    end

    // sweep pipeline data path
    always_ff @(posedge i_clk) begin
        r_s1_col <= issue_col;
        r_s2_col <= r_s1_col;
        r_s2_val <= n_prod[ENTRY_W+KEEP_W-1:KEEP_W];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_deposit   <= '0;
            r_row_valid <= '0;
            r_fc_valid  <= 1'b0;
            r_issue     <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_v <= issue_go;
            r_s2_v <= r_s1_v;
            // output register emptied unless it is reloaded below
            if (m_acc && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_node      <= in_node;
                        r_row       <= in_row;
                        r_cost      <= in_cost;
                        r_rfirst    <= in_rfirst;
                        r_res_value <= '0;
                        r_res_sat   <= 1'b0;
                        r_issue     <= '0;
                        case (in_action)
                            ACT_TOUR: begin
                                if ({1'b0, in_node} < CNT_W'(NODES)) begin
                                    r_prev <= in_node;
                                    if (in_start) begin
                                        r_line_fc <= 1'b1;
                                        if (in_cost == '0) begin
                                            r_deposit <= ENTRY_MAX;
                                            r_state   <= S_SWEEP;
                                        end else begin
                                            r_rem     <= '0;
                                            r_quo     <= r_dscale;
                                            r_div_cnt <= '0;
                                            r_state   <= S_DIV;
                                        end
                                    end else if ({1'b0, r_prev} < CNT_W'(NODES)) begin
                                        r_line_fc  <= 1'b0;
                                        r_line_row <= r_prev;
                                        r_state    <= S_SWEEP;
                                    end else begin
                                        r_state <= S_FIN;
                                    end
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            ACT_READ: r_state <= S_READ;
                            ACT_INIT: begin
                                r_row_valid <= '0;
                                r_fc_valid  <= 1'b0;
                                r_state     <= S_FIN;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                // one quotient bit per cycle
                S_DIV: begin
                    r_rem     <= n_ge ? n_diff[COST_W-1:0] : n_trial[COST_W-1:0];
                    r_quo     <= {r_quo[ENTRY_W-2:0], n_ge};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_W'(ENTRY_W - 1)) begin
                        r_deposit <= {r_quo[ENTRY_W-2:0], n_ge};
                        r_state   <= S_SWEEP;
                    end
                end
                // read, scale, deposit and write back one entry per cycle
                S_SWEEP: begin
                    if (issue_go) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (r_s2_v && wb_sat) begin
                        r_res_sat <= 1'b1;
                    end
                    if (!issue_go && !r_s1_v && !r_s2_v) begin
                        if (r_line_fc) begin
                            r_fc_valid <= 1'b1;
                        end else begin
                            r_row_valid[r_line_row] <= 1'b1;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_READ: r_state <= S_RDATA;
                S_RDATA: begin
                    r_res_value <= rd_value;
                    r_state     <= S_FIN;
                end
                // hand the result to the output register
                S_FIN: begin
                    if (!r_out_valid || m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res_value;
                        r_out_sat   <= r_res_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* tb/pheromone_matrix_update_test.sv */
module pheromone_matrix_update_test;

    import pmu_pkg::*;

    // spare action code, ignored by the block
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // register byte addresses
    localparam logic [APB_AW-1:0] KEEP_ADDR    = {REG_KEEP, 2'b00};
    localparam logic [APB_AW-1:0] DEPOSIT_ADDR = {REG_DEPOSIT, 2'b00};

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 120;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] node;
        logic              start;
        logic [COST_W-1:0] cost;
        logic [NODE_W-1:0] row;
        logic              pick_first;
    } t_word;

    typedef struct packed {
        logic [ENTRY_W-1:0] value;
        logic               saturated;
    } t_reply;

    // directed row: one input word, and a typed-in reply where it is obvious
    typedef struct packed {
        logic [1:0]         action;
        logic [NODE_W-1:0]  node;
        logic               start;
        logic [COST_W-1:0]  cost;
        logic [NODE_W-1:0]  row;
        logic               pick_first;
        logic               typed;
        logic [ENTRY_W-1:0] t_value;
        logic               t_sat;
    } t_probe;

    t_probe probes [24] = '{
        // store contents right after reset
        '{ACT_READ,  6'd1,  1'b0, 7'd0,   6'd0,  1'b0, 1'b1, SHARE, 1'b0},
        '{ACT_READ,  6'd5,  1'b0, 7'd0,   6'd5,  1'b0, 1'b1, 32'd0, 1'b0},
        '{ACT_READ,  6'd63, 1'b0, 7'd0,   6'd0,  1'b1, 1'b1, SHARE, 1'b0},
        // tour node with no tour started yet
        '{ACT_TOUR,  6'd7,  1'b0, 7'd0,   6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_READ,  6'd7,  1'b0, 7'd0,   6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        // tours over the edge nodes, smallest and largest usual cost
        '{ACT_TOUR,  6'd0,  1'b1, 7'd1,   6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_TOUR,  6'd63, 1'b0, 7'd0,   6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_TOUR,  6'd0,  1'b0, 7'd0,   6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_TOUR,  6'd63, 1'b1, 7'd64,  6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        // zero cost gives the all-ones deposit
        '{ACT_TOUR,  6'd10, 1'b1, 7'd0,   6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_TOUR,  6'd20, 1'b0, 7'd0,   6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_TOUR,  6'd20, 1'b0, 7'd0,   6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_READ,  6'd10, 1'b0, 7'd0,   6'd0,  1'b1, 1'b0, 32'd0, 1'b0},
        '{ACT_READ,  6'd20, 1'b0, 7'd0,   6'd20, 1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_READ,  6'd0,  1'b0, 7'd0,   6'd63, 1'b0, 1'b0, 32'd0, 1'b0},
        // spare action with every field high
        '{ACT_SPARE, 6'd63, 1'b1, 7'd127, 6'd63, 1'b1, 1'b1, 32'd0, 1'b0},
        // init, then the store is back to its reset contents
        '{ACT_INIT,  6'd0,  1'b0, 7'd0,   6'd0,  1'b0, 1'b1, 32'd0, 1'b0},
        '{ACT_READ,  6'd20, 1'b0, 7'd0,   6'd20, 1'b0, 1'b1, 32'd0, 1'b0},
        '{ACT_READ,  6'd10, 1'b0, 7'd0,   6'd0,  1'b1, 1'b1, SHARE, 1'b0},
        // init keeps the previous node and deposit
        '{ACT_TOUR,  6'd5,  1'b0, 7'd0,   6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_TOUR,  6'd1,  1'b1, 7'd127, 6'd0,  1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_READ,  6'd63, 1'b0, 7'd0,   6'd63, 1'b0, 1'b0, 32'd0, 1'b0},
        '{ACT_READ,  6'd63, 1'b1, 7'd127, 6'd63, 1'b1, 1'b0, 32'd0, 1'b0},
        '{ACT_INIT,  6'd63, 1'b1, 7'd127, 6'd63, 1'b1, 1'b1, 32'd0, 1'b0}
    };

    // random phases: word count per register setting
    int phase_len [5] = '{100, 50, 100, 100, 50};

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // predicted pheromone store and registers
    logic [ENTRY_W-1:0] trail [NODES*NODES];
    logic [ENTRY_W-1:0] first_pick [NODES];
    logic [NODE_W-1:0]  last_node;
    logic [ENTRY_W-1:0] tour_dep;
    logic [KEEP_W-1:0]  keep;
    logic [ENTRY_W-1:0] dep_scale;

    t_reply trail_replies [$];

    int unsigned cycle_count     = 0;
    int          words_sent      = 0;
    int          replies_checked = 0;
    int          sat_seen        = 0;
    int          settings_used   = 1;
    int          errors          = 0;

    pheromone_matrix_update dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // store back to 1/n with a zero diagonal
    function automatic void refill_trails();
        for (int r = 0; r < NODES; r++) begin
            first_pick[r] = SHARE;
            for (int c = 0; c < NODES; c++) begin
                trail[r*NODES + c] = (r == c) ? '0 : SHARE;
            end
        end
    endfunction

    // evaporate one entry, add the deposit where hit, clamp at the top
    function automatic logic [ENTRY_W-1:0] fade_add(input logic [ENTRY_W-1:0] v,
                                                    input logic hit, inout logic sat);
        logic [63:0] prod;
        logic [32:0] sum;
        prod = 64'(v) * 64'(keep);
        sum  = {1'b0, prod[47:16]};
        if (hit) begin
            sum = sum + 33'(tour_dep);
        end
        if (sum[32]) begin
            sat = 1'b1;
            return ENTRY_MAX;
        end
        return sum[31:0];
    endfunction

    // reply of one word, updating the predicted store
    function automatic t_reply step_trails(input t_word w);
        t_reply r;
        int     base;
        r    = '0;
        base = int'(last_node) * NODES;
        case (w.action)
            ACT_TOUR: begin
                if (w.start) begin
                    tour_dep = (w.cost == 0) ? ENTRY_MAX : dep_scale / 32'(w.cost);
                    for (int i = 0; i < NODES; i++) begin
                        first_pick[i] = fade_add(first_pick[i], i == int'(w.node),
                                                 r.saturated);
                    end
                end else begin
                    for (int i = 0; i < NODES; i++) begin
                        trail[base + i] = fade_add(trail[base + i], i == int'(w.node),
                                                   r.saturated);
                    end
                end
                last_node = w.node;
            end
            ACT_READ: begin
                if (w.pick_first) begin
                    r.value = first_pick[w.node];
                end else begin
                    r.value = trail[int'(w.row)*NODES + int'(w.node)];
                end
            end
            ACT_INIT: begin
                refill_trails();
            end
            default: ;
        endcase
        return r;
    endfunction

    // random word: mostly tours, many reads, half of them on the current row, a few inits and spare words
    function automatic t_word rand_word();
        t_word w;
        int    pick;
        w    = '0;
        pick = $urandom_range(0, 99);
        w.node = NODE_W'($urandom_range(0, NODES-1));
        if (pick < 60) begin
            w.action = ACT_TOUR;
            w.start  = ($urandom_range(0, 7) == 0);
            pick     = $urandom_range(0, 9);
            if (pick == 0) begin
                w.cost = '0;
            end else if (pick == 1) begin
                w.cost = COST_W'($urandom_range(65, 127));
            end else begin
                w.cost = COST_W'($urandom_range(1, 64));
            end
            w.row        = NODE_W'($urandom);
            w.pick_first = 1'($urandom);
        end else if (pick < 92) begin
            w.action     = ACT_READ;
            w.pick_first = ($urandom_range(0, 3) == 0);
            w.row        = $urandom_range(0, 1) ? last_node : NODE_W'($urandom);
            w.cost       = COST_W'($urandom);
        end else if (pick < 96) begin
            w.action = ACT_INIT;
        end else begin
            w.action     = ACT_SPARE;
            w.start      = 1'($urandom);
            w.cost       = COST_W'($urandom);
            w.row        = NODE_W'($urandom);
            w.pick_first = 1'($urandom);
        end
        return w;
    endfunction

    // offer one word, predict its reply once it is taken
    task automatic send_word(input t_word w, input logic typed, input t_reply fixed);
        int     gap;
        t_reply model;
        gap = ((words_sent / 37) % 3 == 1) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, w.row, w.cost, w.start, w.node};
        s_tuser  <= {w.pick_first, w.action};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        model = step_trails(w);
        if (typed) begin
            model = fixed;
        end
        trail_replies = {trail_replies, model};
        words_sent++;
    endtask

    // register write: setup then access, then the bus goes idle
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == KEEP_ADDR) begin
            keep = data[KEEP_W-1:0];
        end else begin
            dep_scale = data;
        end
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (trail_replies.size() != 0) @(posedge i_clk);
    endtask

    // stimulus and register phases
    initial begin : feed_side
        t_word  w;
        t_reply fixed;
        refill_trails();
        keep      = KEEP_RESET;
        dep_scale = DEPOSIT_RESET;
        last_node = '0;
        tour_dep  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[k]) begin
            w     = '{probes[k].action, probes[k].node, probes[k].start, probes[k].cost,
                      probes[k].row, probes[k].pick_first};
            fixed = '{probes[k].t_value, probes[k].t_sat};
            send_word(w, probes[k].typed, fixed);
        end

        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                s_tvalid <= 1'b0;
                wait_drained();
                case (p)
                    1: begin
                        write_reg(KEEP_ADDR, 32'd0);
                        write_reg(DEPOSIT_ADDR, 32'd0);
                    end
                    2: begin
                        write_reg(KEEP_ADDR, 32'h0000_FFFF);
                        write_reg(DEPOSIT_ADDR, 32'hFFFF_FFFF);
                    end
                    3: begin
                        write_reg(KEEP_ADDR, 32'($urandom_range(0, 65535)));
                        write_reg(DEPOSIT_ADDR, $urandom);
                    end
                    default: begin
                        write_reg(KEEP_ADDR, 32'($urandom_range(40000, 65535)));
                        write_reg(DEPOSIT_ADDR, $urandom_range(0, 32'h00FF_FFFF));
                    end
                endcase
                settings_used++;
            end
            repeat (phase_len[p]) send_word(rand_word(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("sent %0d words over %0d register settings, %0d replies checked",
                 words_sent, settings_used, replies_checked);
        $display("%0d replies carried the saturation flag", sat_seen);
        if (errors == 0 && trail_replies.size() == 0) begin
            $display("** pheromone_matrix_update: PASSED **");
        end else begin
            $display("** pheromone_matrix_update: FAILED **");
        end
        $finish;
    end

    // reply side: random stalls, one long hold-off, field checks
    initial begin : reply_side
        int     stall;
        bit     held;
        t_reply want;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && replies_checked >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = ((replies_checked / 29) % 3 == 2) ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            replies_checked++;
            if (trail_replies.size() == 0) begin
                $error("reply with nothing pending: value %h saturated %b",
                       m_tdata, m_tuser[0]);
                errors++;
            end else begin
                want = trail_replies.pop_front();
                if (m_tdata !== want.value) begin
                    $error("value: expected %h, got %h", want.value, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, m_tuser[0]);
                    errors++;
                end
                if (want.saturated) begin
                    sat_seen++;
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("run limit of %0d cycles reached, %0d replies still pending",
                 CYCLE_LIMIT, trail_replies.size());
        $display("** pheromone_matrix_update: FAILED **");
        $finish;
    end

endmodule
